FILE: sv/steq_pkg.sv
// ----------------------------------------------------------------------------
// steq_pkg
// Shared types and constants of the sorted timer event queue: command and
// result codes, the per-tick firing limit, and the control and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package steq_pkg;

  // Input command codes.
  typedef enum logic {
    CmdTick = 1'b0,
    CmdAdd  = 1'b1
  } cmd_e;

  // Result codes carried in event_res.
  localparam logic [1:0] EvAdded = 2'd0;
  localparam logic [1:0] EvFull  = 2'd1;
  localparam logic [1:0] EvFired = 2'd2;

  // At most this many entries fire on one tick.
  localparam int MaxResults = 16;
  localparam int FireCntW   = $clog2(MaxResults);

  // Controller to datapath commands.
  typedef struct packed {
    logic take_in;    // latch the input transaction, advance the tick on a tick
    logic scan_inc;   // step the free-slot scan to the next slot
    logic add_ok;     // insert the new entry and load an added result
    logic add_full;   // load a pool-full result
    logic fire;       // pop the head entry and load a fired result
    logic fire_last;  // last flag of the fired result
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic slot_free;  // slot under the scan is free
    logic scan_end;   // scan is at the highest slot
    logic has_one;    // at least one entry queued
    logic has_two;    // at least two entries queued
    logic head_due;   // head entry is due at the current tick
    logic next_due;   // entry behind the head is due at the current tick
    logic can_load;   // output register can take a result this cycle
  } dp_status_t;

endpackage

FILE: sv/steq_in_if.sv
// ----------------------------------------------------------------------------
// steq_in_if
// Input channel of the sorted timer event queue: one command per transaction.
// ----------------------------------------------------------------------------
interface steq_in_if #(
  parameter int TICK_WIDTH = 32,
  parameter int TAG_WIDTH  = 8
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [TICK_WIDTH-1:0] due_time;
  logic [TAG_WIDTH-1:0]  tag;

  modport source (output valid, command, due_time, tag, input ready);
  modport sink   (input valid, command, due_time, tag, output ready);
endinterface

FILE: sv/steq_out_if.sv
// ----------------------------------------------------------------------------
// steq_out_if
// Result channel of the sorted timer event queue: one result per transaction.
// ----------------------------------------------------------------------------
interface steq_out_if #(
  parameter int TICK_WIDTH = 32,
  parameter int TAG_WIDTH  = 8,
  parameter int SLOT_W     = 4
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            event_res;
  logic [SLOT_W-1:0]     slot;
  logic [TAG_WIDTH-1:0]  fired_tag;
  logic [TICK_WIDTH-1:0] entry_time;
  logic [TICK_WIDTH-1:0] now;
  logic                  last;

  modport source (output valid, event_res, slot, fired_tag, entry_time, now, last,
                  input ready);
  modport sink   (input valid, event_res, slot, fired_tag, entry_time, now, last,
                  output ready);
endinterface

FILE: sv/steq_ctrl.sv
// ----------------------------------------------------------------------------
// steq_ctrl
// Controller of the sorted timer event queue. Takes one command at a time,
// walks the free-slot scan for an add and pops due entries for a tick.
// ----------------------------------------------------------------------------
module steq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_command_i,
  output logic                 in_ready_o,
  input  steq_pkg::dp_status_t status_i,
  output steq_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFire
  } state_e;

  state_e                        state_q, state_d;
  logic [steq_pkg::FireCntW-1:0] fired_q, fired_d;
  logic                          limit_hit;

  // The last allowed firing of one tick.
  assign limit_hit  = (fired_q == steq_pkg::FireCntW'(steq_pkg::MaxResults - 1));
  assign in_ready_o = (state_q == StIdle);

  // Next state and commands to the datapath.
  always_comb begin
    state_d = state_q;
    fired_d = fired_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          fired_d       = '0;
          if (in_command_i == steq_pkg::CmdAdd) begin
            state_d = StScan;
          end else begin
            state_d = StFire;
          end
        end
      end
      StScan: begin
        if (status_i.slot_free) begin
          if (status_i.can_load) begin
            cmd_o.add_ok = 1'b1;
            state_d      = StIdle;
          end
        end else if (status_i.scan_end) begin
          if (status_i.can_load) begin
            cmd_o.add_full = 1'b1;
            state_d        = StIdle;
          end
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      StFire: begin
        if (status_i.has_one && status_i.head_due) begin
          if (status_i.can_load) begin
            cmd_o.fire      = 1'b1;
            cmd_o.fire_last = limit_hit || !(status_i.has_two && status_i.next_due);
            fired_d         = fired_q + 1'b1;
            if (cmd_o.fire_last) begin
              state_d = StIdle;
            end
          end
        end else begin
          // Nothing due on this tick.
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and firing count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fired_q <= '0;
    end else begin
      state_q <= state_d;
      fired_q <= fired_d;
    end
  end

endmodule

FILE: sv/steq_dp.sv
// ----------------------------------------------------------------------------
// steq_dp
// Datapath of the sorted timer event queue: tick counter, slot busy flags,
// a row of cells that holds the entries in due-time order, and the output
// register.
// ----------------------------------------------------------------------------
module steq_dp #(
  parameter int NUM_SLOTS  = 16,
  parameter int TICK_WIDTH = 32,
  parameter int TAG_WIDTH  = 8,
  parameter int SLOT_W     = $clog2(NUM_SLOTS),
  parameter int CNT_W      = $clog2(NUM_SLOTS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  steq_pkg::ctrl_cmd_t   cmd_i,
  output steq_pkg::dp_status_t  status_o,
  input  logic                  in_command_i,
  input  logic [TICK_WIDTH-1:0] in_due_time_i,
  input  logic [TAG_WIDTH-1:0]  in_tag_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            out_event_res_o,
  output logic [SLOT_W-1:0]     out_slot_o,
  output logic [TAG_WIDTH-1:0]  out_fired_tag_o,
  output logic [TICK_WIDTH-1:0] out_entry_time_o,
  output logic [TICK_WIDTH-1:0] out_now_o,
  output logic                  out_last_o
);

  logic [TICK_WIDTH-1:0] now_q;
  logic [NUM_SLOTS-1:0]  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [SLOT_W-1:0]     scan_q;
  logic [TICK_WIDTH-1:0] due_q;
  logic [TAG_WIDTH-1:0]  tag_q;

  logic [TICK_WIDTH-1:0] cell_due_q  [NUM_SLOTS];
  logic [TAG_WIDTH-1:0]  cell_tag_q  [NUM_SLOTS];
  logic [SLOT_W-1:0]     cell_slot_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  place;

  logic                  out_valid_q;
  logic [1:0]            out_ev_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic [TAG_WIDTH-1:0]  out_tag_q;
  logic [TICK_WIDTH-1:0] out_time_q;
  logic [TICK_WIDTH-1:0] out_now_q;
  logic                  out_last_q;

  // Status toward the controller.
  assign status_o.slot_free = !busy_q[scan_q];
  assign status_o.scan_end  = (scan_q == SLOT_W'(NUM_SLOTS - 1));
  assign status_o.has_one   = (cnt_q != '0);
  assign status_o.has_two   = (cnt_q > CNT_W'(1));
  assign status_o.head_due  = (cell_due_q[0] <= now_q);
  assign status_o.next_due  = (cell_due_q[1] <= now_q);
  assign status_o.can_load  = !out_valid_q || out_ready_i;

  // Control registers: tick count, busy flags, queue length, scan pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q  <= '0;
      busy_q <= '0;
      cnt_q  <= '0;
      scan_q <= '0;
    end else begin
      if (cmd_i.take_in) begin
        scan_q <= '0;
        if (in_command_i == steq_pkg::CmdTick) begin
          now_q <= now_q + 1'b1;
        end
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.add_ok) begin
        busy_q[scan_q] <= 1'b1;
        cnt_q          <= cnt_q + 1'b1;
      end else if (cmd_i.fire) begin
        busy_q[cell_slot_q[0]] <= 1'b0;
        cnt_q                  <= cnt_q - 1'b1;
      end
    end
  end

  // Latch of the requested entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      due_q <= in_due_time_i;
      tag_q <= in_tag_i;
    end
  end

  // Row of cells, kept in due-time order. Each cell decides by itself where
  // a new entry lands: the first empty cell or the first one due later.
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    logic                  prev_place;
    logic [TICK_WIDTH-1:0] up_due, dn_due;
    logic [TAG_WIDTH-1:0]  up_tag, dn_tag;
    logic [SLOT_W-1:0]     up_slot, dn_slot;

    assign place[g] = (CNT_W'(g) >= cnt_q) || (cell_due_q[g] > due_q);

    if (g == 0) begin : g_first
      assign prev_place = 1'b0;
      assign up_due     = cell_due_q[g];
      assign up_tag     = cell_tag_q[g];
      assign up_slot    = cell_slot_q[g];
    end else begin : g_rest
      assign prev_place = place[g-1];
      assign up_due     = cell_due_q[g-1];
      assign up_tag     = cell_tag_q[g-1];
      assign up_slot    = cell_slot_q[g-1];
    end

    if (g == NUM_SLOTS - 1) begin : g_tail
      assign dn_due  = cell_due_q[g];
      assign dn_tag  = cell_tag_q[g];
      assign dn_slot = cell_slot_q[g];
    end else begin : g_body
      assign dn_due  = cell_due_q[g+1];
      assign dn_tag  = cell_tag_q[g+1];
      assign dn_slot = cell_slot_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.add_ok && place[g]) begin
        if (prev_place) begin
          cell_due_q[g]  <= up_due;
          cell_tag_q[g]  <= up_tag;
          cell_slot_q[g] <= up_slot;
        end else begin
          cell_due_q[g]  <= due_q;
          cell_tag_q[g]  <= tag_q;
          cell_slot_q[g] <= scan_q;
        end
      end else if (cmd_i.fire) begin
        cell_due_q[g]  <= dn_due;
        cell_tag_q[g]  <= dn_tag;
        cell_slot_q[g] <= dn_slot;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.add_ok || cmd_i.add_full || cmd_i.fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_ok) begin
      out_ev_q   <= steq_pkg::EvAdded;
      out_slot_q <= scan_q;
      out_tag_q  <= tag_q;
      out_time_q <= due_q;
      out_now_q  <= now_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.add_full) begin
      out_ev_q   <= steq_pkg::EvFull;
      out_slot_q <= '0;
      out_tag_q  <= tag_q;
      out_time_q <= due_q;
      out_now_q  <= now_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.fire) begin
      out_ev_q   <= steq_pkg::EvFired;
      out_slot_q <= cell_slot_q[0];
      out_tag_q  <= cell_tag_q[0];
      out_time_q <= cell_due_q[0];
      out_now_q  <= now_q;
      out_last_q <= cmd_i.fire_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_event_res_o  = out_ev_q;
  assign out_slot_o       = out_slot_q;
  assign out_fired_tag_o  = out_tag_q;
  assign out_entry_time_o = out_time_q;
  assign out_now_o        = out_now_q;
  assign out_last_o       = out_last_q;

endmodule

FILE: sv/sorted_timer_event_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// A pool of timer slots kept in due-time order. An add takes the lowest free
// slot and inserts it after every entry due at the same time or earlier; a
// tick advances the tick count and emits the entries now due, in order.
//
//   Channel  Direction  Transaction
//   in_i     sink       command, due_time, tag
//   out_o    source     event_res, slot, fired_tag, entry_time, now, last
//
// During an add the free-slot scan tests one slot per cycle, and all the ordered
// cells take the insert together.
// A tick fires at most 16 of the entries now due, and emits no result when
// nothing is due.
// Reset clears the tick count, the busy flags and the queue length at once.
// A full output register holds back the result of an add, or the firing, until it is taken.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue #(
  parameter int NUM_SLOTS  = 16,
  parameter int TICK_WIDTH = 32,
  parameter int TAG_WIDTH  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  steq_in_if.sink    in_i,
  steq_out_if.source out_o
);

  steq_pkg::ctrl_cmd_t  cmd;
  steq_pkg::dp_status_t status;
  logic                 in_ready;

  assign in_i.ready = in_ready;

  // Command sequencing.
  steq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Timer storage and result register.
  steq_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TICK_WIDTH (TICK_WIDTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .in_command_i     (in_i.command),
    .in_due_time_i    (in_i.due_time),
    .in_tag_i         (in_i.tag),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_event_res_o  (out_o.event_res),
    .out_slot_o       (out_o.slot),
    .out_fired_tag_o  (out_o.fired_tag),
    .out_entry_time_o (out_o.entry_time),
    .out_now_o        (out_o.now),
    .out_last_o       (out_o.last)
  );

endmodule
